// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file of the upscaler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define IBU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ibu checker: property failed");

// Same shape, but also checked while reset is applied.
`define IBU_ASSERT_NEXT_NR(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ibu checker: property failed");

`endif

// ----- hw/rtl/ibu_pkg.sv -----
// Shared constants, types and register codes of the integer bilinear upscaler.
package ibu_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_SCALE  = 4;
    localparam int MAX_HEIGHT = 4096;

    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;
    localparam int PIX_W    = CH_W * NUM_CH;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int IMG_W_W  = 11;
    localparam int IMG_H_W  = 13;
    localparam int SCALE_W  = 3;
    localparam int MODE_W   = 1;
    localparam int X_W      = 12;
    localparam int Y_W      = 14;
    localparam int WGT_W    = 3;
    localparam int TOP_W    = 10;
    localparam int SUM_W    = 12;
    localparam int NUM_BLK  = 4;

    // Division by nine as a multiplication by a scaled reciprocal.
    localparam int RECIP_W  = 13;
    localparam int RECIP_SH = 16;
    localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(7282);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_SCALE_FACTOR,
        CFG_INTERP_MODE
    } t_cfg_idx;

    // Side information that travels beside the lane data.
    typedef struct packed {
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic               last;
        logic [SCALE_W-1:0] scale;
    } t_meta;

    typedef struct packed {
        t_meta              m;
        logic [WGT_W-1:0]   wy0;
        logic [WGT_W-1:0]   wy1;
    } t_stage1;

    typedef struct packed {
        logic [X_W-1:0]  x;
        logic [Y_W-1:0]  y;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } t_result;

endpackage

// ----- hw/rtl/ibu_pix_if.sv -----
// Source pixel channel of the upscaler.
interface ibu_pix_if;
    logic                     valid;
    logic                     ready;
    logic [ibu_pkg::CH_W-1:0] red_in;
    logic [ibu_pkg::CH_W-1:0] green_in;
    logic [ibu_pkg::CH_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in, input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

// ----- hw/rtl/ibu_res_if.sv -----
// Result pixel channel of the upscaler.
interface ibu_res_if;
    logic                     valid;
    logic                     ready;
    logic [ibu_pkg::X_W-1:0]  out_x;
    logic [ibu_pkg::Y_W-1:0]  out_y;
    logic [ibu_pkg::CH_W-1:0] red_out;
    logic [ibu_pkg::CH_W-1:0] green_out;
    logic [ibu_pkg::CH_W-1:0] blue_out;
    logic                     last_of_run;

    modport source (output valid, output out_x, output out_y, output red_out,
                    output green_out, output blue_out, output last_of_run, input ready);
    modport sink (input valid, input out_x, input out_y, input red_out,
                  input green_out, input blue_out, input last_of_run, output ready);
endinterface

// ----- hw/rtl/ibu_cfg_if.sv -----
// Configuration write channel of the upscaler.
interface ibu_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ibu_pkg::CFG_IDX_W-1:0]  index;
    logic [ibu_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/integer_bilinear_upscaler_core.sv -----
// Integer-factor bilinear / nearest upscaler for a raster stream of RGB pixels.
//
//  channel   dir  modport  carries
//  i_pix     in   sink     red_in, green_in, blue_in
//  o_res     out  source   out_x, out_y, red_out, green_out, blue_out, last_of_run
//  i_cfg     in   sink     index, data (ready held high)
//
//  A pixel passes ST_IDLE and ST_PREP and then releases N results (0 to 4*S*S, 1 when
//  the scale is zero); the sequencer issues one output pixel per cycle unless stalled.
//  The row store read is registered, so the blocks of a pixel are issued after ST_PREP.
//  Results pass two lane stages and the result register after issue.
//  Reset clears configuration to its defaults, counters and the neighbour holds;
//  the row store is not cleared. A stalled result freezes the lanes and the sequencer.
module integer_bilinear_upscaler_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ibu_pix_if.sink    i_pix,
    ibu_res_if.source  o_res,
    ibu_cfg_if.sink    i_cfg
);
    typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_EMIT} t_state;

    localparam int CW  = ibu_pkg::CH_W;
    localparam int NCH = ibu_pkg::NUM_CH;

    // Configuration
    logic [ibu_pkg::IMG_W_W-1:0] r_img_width;
    logic [ibu_pkg::IMG_H_W-1:0] r_img_height;
    logic [ibu_pkg::SCALE_W-1:0] r_scale;
    logic [ibu_pkg::MODE_W-1:0]  r_mode;
    logic [ibu_pkg::IMG_W_W-1:0] w_width;
    logic [ibu_pkg::IMG_H_W-1:0] w_height;
    logic [ibu_pkg::SCALE_W-1:0] w_scale;

    // Sequencer
    t_state                       r_state, n_state;
    logic [ibu_pkg::COL_W-1:0]    r_col;
    logic [ibu_pkg::ROW_W-1:0]    r_row;
    logic [ibu_pkg::COL_W-1:0]    r_c;
    logic [ibu_pkg::ROW_W-1:0]    r_r;
    logic [ibu_pkg::PIX_W-1:0]    r_px;
    logic [ibu_pkg::PIX_W-1:0]    r_above;
    logic [ibu_pkg::PIX_W-1:0]    r_ul_blk;
    logic [ibu_pkg::PIX_W-1:0]    r_left_blk;
    logic [ibu_pkg::PIX_W-1:0]    r_ul_hold;
    logic [ibu_pkg::PIX_W-1:0]    r_left_hold;
    logic [ibu_pkg::NUM_BLK-1:0]  r_mask, n_mask;
    logic [ibu_pkg::SCALE_W-1:0]  r_blk_s;
    logic                         r_nearest;
    logic [1:0]                   r_dx, n_dx;
    logic [1:0]                   r_dy, n_dy;

    logic                         w_acc_in;
    logic                         w_acc_cfg;
    logic [ibu_pkg::PIX_W-1:0]    w_rd_data;
    logic                         w_lastcol;
    logic                         w_lastrow;
    logic [ibu_pkg::NUM_BLK-1:0]  w_new_mask;
    logic [1:0]                   w_blk;
    logic [ibu_pkg::NUM_BLK-1:0]  w_rest;
    logic [ibu_pkg::COL_W-1:0]    w_ax;
    logic [ibu_pkg::ROW_W-1:0]    w_ay;
    logic [ibu_pkg::PIX_W-1:0]    w_ul, w_ur, w_ll, w_lr;
    logic [ibu_pkg::WGT_W-1:0]    w_wx0, w_wx1, w_wy0, w_wy1;
    logic                         w_end_dx, w_end_dy;
    logic                         w_issue;
    ibu_pkg::t_stage1             w_stage1;

    // Pipeline beside the lanes
    logic                         w_en;
    logic                         r_v1, r_v2;
    ibu_pkg::t_stage1             r_meta1;
    ibu_pkg::t_meta               r_meta2;
    logic [NCH-1:0][ibu_pkg::SUM_W-1:0] w_sum;
    ibu_pkg::t_result             w_res;

    assign w_acc_in  = i_pix.valid && i_pix.ready;
    assign w_acc_cfg = i_cfg.valid && i_cfg.ready;
    assign i_pix.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    // Out-of-range settings fold onto the nearest legal value.
    always_comb begin
        if (r_img_width == '0) begin
            w_width = ibu_pkg::IMG_W_W'(1);
        end else if (r_img_width > ibu_pkg::IMG_W_W'(ibu_pkg::MAX_WIDTH)) begin
            w_width = ibu_pkg::IMG_W_W'(ibu_pkg::MAX_WIDTH);
        end else begin
            w_width = r_img_width;
        end
        if (r_img_height == '0) begin
            w_height = ibu_pkg::IMG_H_W'(1);
        end else if (r_img_height > ibu_pkg::IMG_H_W'(ibu_pkg::MAX_HEIGHT)) begin
            w_height = ibu_pkg::IMG_H_W'(ibu_pkg::MAX_HEIGHT);
        end else begin
            w_height = r_img_height;
        end
        if (r_scale > ibu_pkg::SCALE_W'(ibu_pkg::MAX_SCALE)) begin
            w_scale = ibu_pkg::SCALE_W'(ibu_pkg::MAX_SCALE);
        end else begin
            w_scale = r_scale;
        end
    end

    ibu_ram #(
        .WIDTH (ibu_pkg::PIX_W),
        .DEPTH (ibu_pkg::MAX_WIDTH)
    ) u_row_store (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == ST_PREP),
        .i_wr_addr (r_c),
        .i_wr_data (r_px),
        .i_rd_en   (w_acc_in),
        .i_rd_addr (r_col),
        .o_rd_data (w_rd_data)
    );

    // Which blocks this pixel completes: bit 0 is the block up-left of it, then
    // the one above, the one to the left, and its own block.
    always_comb begin
        w_lastcol = (ibu_pkg::IMG_W_W'(r_c) + 1'b1) >= w_width;
        w_lastrow = (ibu_pkg::IMG_H_W'(r_r) + 1'b1) >= w_height;
        if (w_scale == '0) begin
            w_new_mask = 4'b1000;
        end else begin
            w_new_mask = {w_lastrow && w_lastcol, w_lastrow && (r_c != '0),
                          (r_r != '0) && w_lastcol, (r_r != '0) && (r_c != '0)};
        end
    end

    always_comb begin
        if (r_mask[0]) begin
            w_blk = 2'd0;
        end else if (r_mask[1]) begin
            w_blk = 2'd1;
        end else if (r_mask[2]) begin
            w_blk = 2'd2;
        end else begin
            w_blk = 2'd3;
        end
        w_rest = r_mask & ~(ibu_pkg::NUM_BLK'(1) << w_blk);

        case (w_blk)
            2'd0: begin
                w_ax = r_c - 1'b1;  w_ay = r_r - 1'b1;
                w_ul = r_ul_blk;    w_ur = r_above;
                w_ll = r_left_blk;  w_lr = r_px;
            end
            2'd1: begin
                w_ax = r_c;         w_ay = r_r - 1'b1;
                w_ul = r_above;     w_ur = r_above;
                w_ll = r_px;        w_lr = r_px;
            end
            2'd2: begin
                w_ax = r_c - 1'b1;  w_ay = r_r;
                w_ul = r_left_blk;  w_ur = r_px;
                w_ll = r_left_blk;  w_lr = r_px;
            end
            default: begin
                w_ax = r_c;         w_ay = r_r;
                w_ul = r_px;        w_ur = r_px;
                w_ll = r_px;        w_lr = r_px;
            end
        endcase

        // Nearest mode puts the whole weight on the anchor pixel.
        w_wx1 = r_nearest ? '0 : ibu_pkg::WGT_W'(r_dx);
        w_wy1 = r_nearest ? '0 : ibu_pkg::WGT_W'(r_dy);
        w_wx0 = r_blk_s - w_wx1;
        w_wy0 = r_blk_s - w_wy1;

        w_end_dx = (ibu_pkg::WGT_W'(r_dx) == r_blk_s - 1'b1);
        w_end_dy = (ibu_pkg::WGT_W'(r_dy) == r_blk_s - 1'b1);

        w_stage1.m.x     = ibu_pkg::X_W'(ibu_pkg::X_W'(w_ax) * ibu_pkg::X_W'(r_blk_s))
                         + ibu_pkg::X_W'(r_dx);
        w_stage1.m.y     = ibu_pkg::Y_W'(ibu_pkg::Y_W'(w_ay) * ibu_pkg::Y_W'(r_blk_s))
                         + ibu_pkg::Y_W'(r_dy);
        w_stage1.m.last  = w_end_dx && w_end_dy && (w_rest == '0);
        w_stage1.m.scale = r_blk_s;
        w_stage1.wy0     = w_wy0;
        w_stage1.wy1     = w_wy1;
    end

    assign w_issue = (r_state == ST_EMIT) && w_en;

    always_comb begin
        n_state = r_state;
        n_mask  = r_mask;
        n_dx    = r_dx;
        n_dy    = r_dy;
        case (r_state)
            ST_IDLE: begin
                if (w_acc_in) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_mask  = w_new_mask;
                n_dx    = '0;
                n_dy    = '0;
                n_state = (w_new_mask == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (w_issue) begin
                    if (!w_end_dx) begin
                        n_dx = r_dx + 1'b1;
                    end else begin
                        n_dx = '0;
                        if (!w_end_dy) begin
                            n_dy = r_dy + 1'b1;
                        end else begin
                            n_dy   = '0;
                            n_mask = w_rest;
                            if (w_rest == '0) begin
                                n_state = ST_IDLE;
                            end
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_img_width  <= ibu_pkg::IMG_W_W'(640);
            r_img_height <= ibu_pkg::IMG_H_W'(480);
            r_scale      <= ibu_pkg::SCALE_W'(2);
            r_mode       <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_ul_hold    <= '0;
            r_left_hold  <= '0;
            r_mask       <= '0;
            r_dx         <= '0;
            r_dy         <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mask  <= n_mask;
            r_dx    <= n_dx;
            r_dy    <= n_dy;

            if (w_acc_cfg) begin
                case (ibu_pkg::t_cfg_idx'(i_cfg.index))
                    ibu_pkg::CFG_IMAGE_WIDTH:  r_img_width  <= i_cfg.data[ibu_pkg::IMG_W_W-1:0];
                    ibu_pkg::CFG_IMAGE_HEIGHT: r_img_height <= i_cfg.data[ibu_pkg::IMG_H_W-1:0];
                    ibu_pkg::CFG_SCALE_FACTOR: r_scale      <= i_cfg.data[ibu_pkg::SCALE_W-1:0];
                    ibu_pkg::CFG_INTERP_MODE:  r_mode       <= i_cfg.data[ibu_pkg::MODE_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == ST_PREP) begin
                r_ul_hold   <= w_rd_data;
                r_left_hold <= r_px;
                if (w_lastcol) begin
                    r_col <= '0;
                    r_row <= w_lastrow ? '0 : r_r + 1'b1;
                end else begin
                    r_col <= r_c + 1'b1;
                end
            end

            if (w_en) begin
                r_v1 <= w_issue;
                r_v2 <= r_v1;
            end
        end

        if (w_acc_in) begin
            r_px <= {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
            r_c  <= r_col;
            r_r  <= r_row;
        end
        if (r_state == ST_PREP) begin
            r_above    <= w_rd_data;
            r_ul_blk   <= r_ul_hold;
            r_left_blk <= r_left_hold;
            r_blk_s    <= (w_scale == '0) ? ibu_pkg::SCALE_W'(1) : w_scale;
            r_nearest  <= r_mode[0];
        end
        if (w_en) begin
            r_meta1 <= w_stage1;
            r_meta2 <= r_meta1.m;
        end
    end

    for (genvar k = 0; k < NCH; k++) begin : g_lane
        ibu_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_ul  (w_ul[(NCH-1-k)*CW +: CW]),
            .i_ur  (w_ur[(NCH-1-k)*CW +: CW]),
            .i_ll  (w_ll[(NCH-1-k)*CW +: CW]),
            .i_lr  (w_lr[(NCH-1-k)*CW +: CW]),
            .i_wx0 (w_wx0),
            .i_wx1 (w_wx1),
            .i_wy0 (r_meta1.wy0),
            .i_wy1 (r_meta1.wy1),
            .o_sum (w_sum[k])
        );
    end

    ibu_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_v2),
        .i_meta  (r_meta2),
        .i_sum   (w_sum),
        .i_ready (o_res.ready),
        .o_valid (o_res.valid),
        .o_res   (w_res),
        .o_en    (w_en)
    );

    assign o_res.out_x       = w_res.x;
    assign o_res.out_y       = w_res.y;
    assign o_res.red_out     = w_res.red;
    assign o_res.green_out   = w_res.green;
    assign o_res.blue_out    = w_res.blue;
    assign o_res.last_of_run = w_res.last;
endmodule

// ----- hw/rtl/ibu_ram.sv -----
// Generic simple dual-port RAM with registered read.
module ibu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- hw/rtl/ibu_lane.sv -----
// One colour channel of the bilinear blend: horizontal then vertical weighting.
module ibu_lane (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ibu_pkg::CH_W-1:0]    i_ul,
    input  logic [ibu_pkg::CH_W-1:0]    i_ur,
    input  logic [ibu_pkg::CH_W-1:0]    i_ll,
    input  logic [ibu_pkg::CH_W-1:0]    i_lr,
    input  logic [ibu_pkg::WGT_W-1:0]   i_wx0,
    input  logic [ibu_pkg::WGT_W-1:0]   i_wx1,
    input  logic [ibu_pkg::WGT_W-1:0]   i_wy0,
    input  logic [ibu_pkg::WGT_W-1:0]   i_wy1,
    output logic [ibu_pkg::SUM_W-1:0]   o_sum
);
    logic [ibu_pkg::TOP_W-1:0] n_top;
    logic [ibu_pkg::TOP_W-1:0] n_bot;
    logic [ibu_pkg::TOP_W-1:0] r_top;
    logic [ibu_pkg::TOP_W-1:0] r_bot;
    logic [ibu_pkg::SUM_W-1:0] n_sum;
    logic [ibu_pkg::SUM_W-1:0] r_sum;

    // The weights never exceed the scale, so the products stay within their widths.
    always_comb begin
        n_top = ibu_pkg::TOP_W'(i_wx0) * ibu_pkg::TOP_W'(i_ul)
              + ibu_pkg::TOP_W'(i_wx1) * ibu_pkg::TOP_W'(i_ur);
        n_bot = ibu_pkg::TOP_W'(i_wx0) * ibu_pkg::TOP_W'(i_ll)
              + ibu_pkg::TOP_W'(i_wx1) * ibu_pkg::TOP_W'(i_lr);
        n_sum = ibu_pkg::SUM_W'(i_wy0) * ibu_pkg::SUM_W'(r_top)
              + ibu_pkg::SUM_W'(i_wy1) * ibu_pkg::SUM_W'(r_bot);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_top <= n_top;
            r_bot <= n_bot;
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;
endmodule

// ----- hw/rtl/ibu_merge.sv -----
// Merging stage: divides the lane sums by the block area and holds the result register.
module ibu_merge (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_load,
    input  ibu_pkg::t_meta                               i_meta,
    input  logic [ibu_pkg::NUM_CH-1:0][ibu_pkg::SUM_W-1:0] i_sum,
    input  logic                                         i_ready,
    output logic                                         o_valid,
    output ibu_pkg::t_result                             o_res,
    output logic                                         o_en
);
    localparam int PROD_W = ibu_pkg::SUM_W + ibu_pkg::RECIP_W;

    logic                                          r_valid;
    ibu_pkg::t_result                              r_res;
    ibu_pkg::t_result                              n_res;
    logic [ibu_pkg::NUM_CH-1:0][ibu_pkg::CH_W-1:0] w_q;
    logic                                          w_en;

    function automatic logic [ibu_pkg::CH_W-1:0] f_div(
        input logic [ibu_pkg::SUM_W-1:0]   sum,
        input logic [ibu_pkg::SCALE_W-1:0] s
    );
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(sum) * PROD_W'(ibu_pkg::RECIP9);
        case (s)
            3'd2:    f_div = sum[2 +: ibu_pkg::CH_W];
            3'd3:    f_div = prod[ibu_pkg::RECIP_SH +: ibu_pkg::CH_W];
            3'd4:    f_div = sum[4 +: ibu_pkg::CH_W];
            default: f_div = sum[ibu_pkg::CH_W-1:0];
        endcase
    endfunction

    always_comb begin
        for (int k = 0; k < ibu_pkg::NUM_CH; k++) begin
            w_q[k] = f_div(i_sum[k], i_meta.scale);
        end
        n_res.x     = i_meta.x;
        n_res.y     = i_meta.y;
        n_res.red   = w_q[0];
        n_res.green = w_q[1];
        n_res.blue  = w_q[2];
        n_res.last  = i_meta.last;
    end

    // The whole pipeline advances only when the result register can take a new value.
    assign w_en = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_load;
        end
        if (w_en && i_load) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_en    = w_en;
endmodule

// ----- hw/rtl/ibu_checker.sv -----
// Port-level checker for the upscaler, bound to the top level.
`include "assert_macros.svh"

module ibu_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_pix_valid,
    input logic                     i_pix_ready,
    input logic                     i_res_valid,
    input logic                     i_res_ready,
    input logic [ibu_pkg::X_W-1:0]  i_res_x,
    input logic [ibu_pkg::Y_W-1:0]  i_res_y,
    input logic [ibu_pkg::CH_W-1:0] i_res_red,
    input logic [ibu_pkg::CH_W-1:0] i_res_green,
    input logic [ibu_pkg::CH_W-1:0] i_res_blue,
    input logic                     i_res_last
);
    // No result may be left over from before a reset.
    `IBU_ASSERT_NEXT_NR(a_reset_empties_output, i_clk, !i_rst_n, !i_res_valid)

    // Every accepted pixel needs a row store read before the next request can enter.
    `IBU_ASSERT_NEXT(a_accept_then_busy, i_clk, i_rst_n, i_pix_valid && i_pix_ready, !i_pix_ready)

    `IBU_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_x) && $stable(i_res_y) && $stable(i_res_red) && $stable(i_res_green) && $stable(i_res_blue) && $stable(i_res_last))
endmodule

bind integer_bilinear_upscaler_core ibu_checker u_ibu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_valid (i_pix.valid),
    .i_pix_ready (i_pix.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_x     (o_res.out_x),
    .i_res_y     (o_res.out_y),
    .i_res_red   (o_res.red_out),
    .i_res_green (o_res.green_out),
    .i_res_blue  (o_res.blue_out),
    .i_res_last  (o_res.last_of_run)
);
